// File: hdl/rayobb_pkg.sv
// shared widths, stage map, register codes and types for the ray/oriented-box slab unit
`timescale 1ns / 1ps
`default_nettype none
package rayobb_pkg;

    // field widths
    localparam int COORD_W   = 32;
    localparam int AXIS_W    = 16;
    localparam int HALF_W    = COORD_W - 1;
    localparam int AXIS_FRAC = AXIS_W - 2;
    localparam int PROD_FRAC = 2 * AXIS_FRAC;

    // datapath widths
    localparam int C_W    = COORD_W + 1;            // center minus origin
    localparam int PE_W   = AXIS_W + C_W;           // axis component times offset
    localparam int ESUM_W = PE_W + 2;               // three-term dot product
    localparam int E_W    = ESUM_W - AXIS_FRAC;     // projected offset, q.16
    localparam int NUM_W  = E_W + 1;                // e plus or minus half extent
    localparam int UN_W   = NUM_W;                  // dividend magnitude
    localparam int PF_W   = 2 * AXIS_W;             // axis component times direction
    localparam int F_W    = PF_W + 2;               // projected direction
    localparam int UD_W   = F_W;                    // divisor magnitude

    // divider geometry: quotient saturates at 2^(COORD_W-1)
    localparam int Q_BITS = COORD_W - 1;
    localparam int QSH    = Q_BITS - PROD_FRAC;     // low dividend bits shifted in
    localparam int HI_W   = UN_W - QSH;
    localparam int DIV_ST = Q_BITS + 1;             // saturation check plus one bit per stage

    localparam logic [UD_W-1:0] NEAR_ZERO =
        UD_W'((64'd1 << PROD_FRAC) / 64'd1000000);

    localparam logic signed [COORD_W-1:0] T_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] T_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    // pipeline stage map
    localparam int ST_IN   = 0;
    localparam int ST_MUL  = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_PREP = 3;
    localparam int ST_DIV  = 4;
    localparam int ST_ORD  = ST_DIV + DIV_ST;
    localparam int ST_RED  = ST_ORD + 1;
    localparam int ST_OUT  = ST_RED + 1;
    localparam int N_ST    = ST_OUT + 1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORG_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_X = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Y = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DIR_Z = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LEN   = 3'd6;

    localparam int IN_TDATA_W  = ((3 * COORD_W + 9 * AXIS_W + 3 * HALF_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((1 + COORD_W + 7) / 8) * 8;

    // per-axis flags that ride alongside the dividers
    typedef struct packed {
        logic [2:0] par;      // direction near zero on that axis
        logic [2:0] pfail;    // parallel and origin outside the slab
        logic [2:0] neg_a;    // quotient sign for e + h
        logic [2:0] neg_b;    // quotient sign for e - h
    } side_t;

endpackage
`default_nettype wire

// File: hdl/rayobb_div.sv
// pipelined saturating restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
`default_nettype none
module rayobb_div (
    input  wire logic                             clk,
    input  wire logic [rayobb_pkg::DIV_ST-1:0]   en,
    input  wire logic [rayobb_pkg::UN_W-1:0]     un,
    input  wire logic [rayobb_pkg::UD_W-1:0]     ud,
    output logic      [rayobb_pkg::COORD_W-1:0]  mag
);
    import rayobb_pkg::*;

    logic [UD_W-1:0]   r_reg   [DIV_ST];
    logic [UD_W-1:0]   ud_reg  [DIV_ST];
    logic [QSH-1:0]    lo_reg  [DIV_ST];
    logic              sat_reg [DIV_ST];
    logic [Q_BITS-1:0] q_reg   [DIV_ST];

    logic [HI_W-1:0] hi;
    assign hi = un[UN_W-1:QSH];

    // first stage: quotient reaches 2^Q_BITS exactly when un/2^QSH >= ud
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            sat_reg[0] <= hi >= HI_W'(ud);
            r_reg[0]   <= UD_W'(hi);
            ud_reg[0]  <= ud;
            lo_reg[0]  <= un[QSH-1:0];
            q_reg[0]   <= '0;
        end
    end

    genvar s;
    generate
        for (s = 1; s < DIV_ST; s++)
        begin : g_step
            localparam int P = Q_BITS - s;   // dividend bit brought in
            logic            bin;
            logic [UD_W:0]   r_next;
            logic            ge;

            if (P >= PROD_FRAC)
            begin : g_data
                assign bin = lo_reg[s-1][P-PROD_FRAC];
            end
            else
            begin : g_zero
                assign bin = 1'b0;
            end

            assign r_next = {r_reg[s-1], bin};
            assign ge     = r_next >= {1'b0, ud_reg[s-1]};

            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    r_reg[s]   <= ge ? UD_W'(r_next - {1'b0, ud_reg[s-1]}) : UD_W'(r_next);
                    q_reg[s]   <= {q_reg[s-1][Q_BITS-2:0], ge};
                    ud_reg[s]  <= ud_reg[s-1];
                    lo_reg[s]  <= lo_reg[s-1];
                    sat_reg[s] <= sat_reg[s-1];
                end
            end
        end
    endgenerate

    assign mag = sat_reg[DIV_ST-1] ? {1'b1, {Q_BITS{1'b0}}} : {1'b0, q_reg[DIV_ST-1]};

endmodule
`default_nettype wire

// File: hdl/ray_obb_slab_intersection_unit.sv
// top level: ray against oriented box slab test, fully pipelined
`timescale 1ns / 1ps
`default_nettype none
// One ray, set through the configuration port, is tested against a stream of oriented boxes.
// Every box request yields one result (hit flag and Q16.16 distance); results leave one
// per cycle in steady state while m_axis_tready stays high. The pipeline holds the six
// 32-stage slab dividers (two per box axis, a saturation check and then one quotient bit per
// stage), preceded by input capture, the projection multipliers, the dot-product adders and
// the dividend setup, and followed by slab ordering, interval reduction and the output
// register. Each stage holds its request while the next stage is full, so a stall at the
// output only backs the pipe up as far as it is occupied and bubbles are squeezed out.
// Config writes are always taken and must only happen while the pipe is empty. A miss
// found on the interval or on a parallel axis returns hit 0 and distance 0; a distance
// behind the origin or beyond ray_length returns hit 0 with the computed distance.
module ray_obb_slab_intersection_unit (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    // config write channel
    input  wire logic                                   cfg_valid,
    output logic                                        cfg_ready,
    input  wire logic [rayobb_pkg::CFG_IDX_W-1:0]      cfg_addr,
    input  wire logic [rayobb_pkg::COORD_W-1:0]        cfg_data,
    // box requests
    input  wire logic                                   s_axis_tvalid,
    output logic                                        s_axis_tready,
    // box_center_x, box_center_y, box_center_z, box_axis_0, box_axis_1, box_axis_2,
    // box_half_x, box_half_y, box_half_z, zero pad
    input  wire logic [rayobb_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // results
    output logic                                        m_axis_tvalid,
    input  wire logic                                   m_axis_tready,
    // hit, distance, zero pad
    output logic      [rayobb_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
    import rayobb_pkg::*;

    // ---------------------------------------------------------------- config
    logic signed [COORD_W-1:0] org_reg [3];
    logic signed [AXIS_W-1:0]  dir_reg [3];
    logic        [HALF_W-1:0]  len_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= AXIS_W'(1) << AXIS_FRAC;
            dir_reg[1] <= '0;
            dir_reg[2] <= '0;
            len_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_addr)
                REG_ORG_X: org_reg[0] <= cfg_data;
                REG_ORG_Y: org_reg[1] <= cfg_data;
                REG_ORG_Z: org_reg[2] <= cfg_data;
                REG_DIR_X: dir_reg[0] <= cfg_data[AXIS_W-1:0];
                REG_DIR_Y: dir_reg[1] <= cfg_data[AXIS_W-1:0];
                REG_DIR_Z: dir_reg[2] <= cfg_data[AXIS_W-1:0];
                REG_LEN:   len_reg    <= cfg_data[HALF_W-1:0];
                default:   ;
            endcase
        end
    end

    // ---------------------------------------------------------------- flow control
    // a stage loads when it is empty or its content moves on
    logic [N_ST-1:0] vld_reg;
    logic [N_ST-1:0] vld_next;
    logic [N_ST-1:0] vld_src;
    logic [N_ST-1:0] en;

    assign vld_src = {vld_reg[N_ST-2:0], s_axis_tvalid};

    always_comb
    begin
        en[N_ST-1] = !vld_reg[N_ST-1] || m_axis_tready;
        for (int i = N_ST - 2; i >= 0; i--)
            en[i] = !vld_reg[i] || en[i+1];
        for (int i = 0; i < N_ST; i++)
            vld_next[i] = en[i] ? vld_src[i] : vld_reg[i];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= vld_next;
    end

    assign s_axis_tready = en[ST_IN];

    // ---------------------------------------------------------------- stage 0: capture
    logic signed [C_W-1:0]      c_reg   [3];
    logic        [3*AXIS_W-1:0] axes_reg[3];
    logic        [HALF_W-1:0]   h0_reg  [3];

    always_ff @(posedge clk)
    begin
        if (en[ST_IN])
        begin
            for (int k = 0; k < 3; k++)
            begin
                // offset from ray origin to box center
                c_reg[k] <= C_W'($signed(s_axis_tdata[k*COORD_W +: COORD_W]))
                          - C_W'(org_reg[k]);
                axes_reg[k] <= s_axis_tdata[3*COORD_W + k*3*AXIS_W +: 3*AXIS_W];
                h0_reg[k]   <= s_axis_tdata[3*COORD_W + 9*AXIS_W + k*HALF_W +: HALF_W];
            end
        end
    end

    // ---------------------------------------------------------------- stage 1: products
    logic signed [PE_W-1:0] pe_reg [3][3];
    logic signed [PF_W-1:0] pf_reg [3][3];
    logic        [HALF_W-1:0] h1_reg [3];

    always_ff @(posedge clk)
    begin
        if (en[ST_MUL])
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    pe_reg[i][k] <= $signed(axes_reg[i][k*AXIS_W +: AXIS_W]) * c_reg[k];
                    pf_reg[i][k] <= $signed(axes_reg[i][k*AXIS_W +: AXIS_W]) * dir_reg[k];
                end
                h1_reg[i] <= h0_reg[i];
            end
        end
    end

    // ---------------------------------------------------------------- stage 2: dot products
    logic signed [ESUM_W-1:0] esum [3];
    logic signed [F_W-1:0]    fsum [3];
    logic signed [E_W-1:0]    e_reg [3];
    logic signed [F_W-1:0]    f_reg [3];
    logic        [HALF_W-1:0] h2_reg [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            esum[i] = ESUM_W'(pe_reg[i][0]) + ESUM_W'(pe_reg[i][1]) + ESUM_W'(pe_reg[i][2]);
            fsum[i] = F_W'(pf_reg[i][0]) + F_W'(pf_reg[i][1]) + F_W'(pf_reg[i][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_SUM])
        begin
            for (int i = 0; i < 3; i++)
            begin
                // floor of the projection, axis fraction bits dropped
                e_reg[i]  <= esum[i][ESUM_W-1:AXIS_FRAC];
                f_reg[i]  <= fsum[i];
                h2_reg[i] <= h1_reg[i];
            end
        end
    end

    // ---------------------------------------------------------------- stage 3: divider setup
    logic [NUM_W-1:0] num_a [3];
    logic [NUM_W-1:0] num_b [3];
    logic [UD_W-1:0]  fmag  [3];
    logic [E_W-1:0]   emag  [3];
    logic [UN_W-1:0]  una_reg [3];
    logic [UN_W-1:0]  unb_reg [3];
    logic [UD_W-1:0]  ud_reg  [3];
    side_t            side_in;
    side_t            side_in_q;
    side_t            side_reg [DIV_ST];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            num_a[i] = NUM_W'(e_reg[i]) + NUM_W'(h2_reg[i]);
            num_b[i] = NUM_W'(e_reg[i]) - NUM_W'(h2_reg[i]);
            fmag[i]  = f_reg[i][F_W-1] ? UD_W'(-f_reg[i]) : UD_W'(f_reg[i]);
            emag[i]  = e_reg[i][E_W-1] ? E_W'(-e_reg[i]) : E_W'(e_reg[i]);
            side_in.par[i]   = fmag[i] <= NEAR_ZERO;
            side_in.pfail[i] = side_in.par[i] && (emag[i] > E_W'(h2_reg[i]));
            side_in.neg_a[i] = num_a[i][NUM_W-1] ^ f_reg[i][F_W-1];
            side_in.neg_b[i] = num_b[i][NUM_W-1] ^ f_reg[i][F_W-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_PREP])
        begin
            for (int i = 0; i < 3; i++)
            begin
                una_reg[i] <= num_a[i][NUM_W-1] ? UN_W'(-num_a[i]) : num_a[i];
                unb_reg[i] <= num_b[i][NUM_W-1] ? UN_W'(-num_b[i]) : num_b[i];
                ud_reg[i]  <= fmag[i];
            end
        end
    end

    // flags follow the dividers stage for stage
    always_ff @(posedge clk)
    begin
        if (en[ST_DIV])
            side_reg[0] <= side_in_q;
        for (int s = 1; s < DIV_ST; s++)
            if (en[ST_DIV + s])
                side_reg[s] <= side_reg[s-1];
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_PREP])
            side_in_q <= side_in;
    end

    // ---------------------------------------------------------------- dividers
    logic [COORD_W-1:0] mag_a [3];
    logic [COORD_W-1:0] mag_b [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++)
        begin : g_axis
            rayobb_div u_div_a (
                .clk (clk),
                .en  (en[ST_DIV +: DIV_ST]),
                .un  (una_reg[g]),
                .ud  (ud_reg[g]),
                .mag (mag_a[g])
            );
            rayobb_div u_div_b (
                .clk (clk),
                .en  (en[ST_DIV +: DIV_ST]),
                .un  (unb_reg[g]),
                .ud  (ud_reg[g]),
                .mag (mag_b[g])
            );
        end
    endgenerate

    // ---------------------------------------------------------------- slab ordering
    logic signed [COORD_W-1:0] ta [3];
    logic signed [COORD_W-1:0] tb [3];
    logic signed [COORD_W-1:0] lo_reg [3];
    logic signed [COORD_W-1:0] hi_reg [3];
    logic                      pfail_reg;
    side_t                     side_out;

    assign side_out = side_reg[DIV_ST-1];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            // negative side keeps -2^31, positive side clips to the largest value
            ta[i] = side_out.neg_a[i] ? COORD_W'(-mag_a[i])
                  : (mag_a[i][COORD_W-1] ? T_MAX : mag_a[i]);
            tb[i] = side_out.neg_b[i] ? COORD_W'(-mag_b[i])
                  : (mag_b[i][COORD_W-1] ? T_MAX : mag_b[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_ORD])
        begin
            for (int i = 0; i < 3; i++)
            begin
                if (side_out.par[i])
                begin
                    // parallel axis leaves the interval open
                    lo_reg[i] <= T_MIN;
                    hi_reg[i] <= T_MAX;
                end
                else if (ta[i] > tb[i])
                begin
                    lo_reg[i] <= tb[i];
                    hi_reg[i] <= ta[i];
                end
                else
                begin
                    lo_reg[i] <= ta[i];
                    hi_reg[i] <= tb[i];
                end
            end
            pfail_reg <= |side_out.pfail;
        end
    end

    // ---------------------------------------------------------------- interval reduction
    logic signed [COORD_W-1:0] tmin;
    logic signed [COORD_W-1:0] tmax;
    logic signed [COORD_W-1:0] tmin_reg;
    logic signed [COORD_W-1:0] tmax_reg;
    logic                      miss_reg;

    always_comb
    begin
        tmin = lo_reg[0];
        tmax = hi_reg[0];
        for (int i = 1; i < 3; i++)
        begin
            if (lo_reg[i] > tmin)
                tmin = lo_reg[i];
            if (hi_reg[i] < tmax)
                tmax = hi_reg[i];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_RED])
        begin
            tmin_reg <= tmin;
            tmax_reg <= tmax;
            // interval bounds only tighten, so an empty final interval is an early miss
            miss_reg <= pfail_reg || (tmin > tmax);
        end
    end

    // ---------------------------------------------------------------- output register
    logic signed [COORD_W-1:0] t_sel;
    logic signed [COORD_W-1:0] dist_reg;
    logic                      hit_reg;

    assign t_sel = tmin_reg[COORD_W-1] ? tmax_reg : tmin_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            dist_reg <= miss_reg ? '0 : t_sel;
            hit_reg  <= !miss_reg && !t_sel[COORD_W-1] && (t_sel <= $signed({1'b0, len_reg}));
        end
    end

    assign m_axis_tvalid = vld_reg[ST_OUT];
    assign m_axis_tdata  = {{(OUT_TDATA_W-COORD_W-1){1'b0}}, dist_reg, hit_reg};

    // ---------------------------------------------------------------- checks
    // a reported hit never lies behind the origin
    a_hit_ahead: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[0] |-> !m_axis_tdata[COORD_W])
        else $error("hit with negative distance");

    // input is refused only with every stage full and the output blocked
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&vld_reg) && !m_axis_tready)
        else $error("input refused while pipeline has room");

    // a request moves into the multiplier stage whenever that stage loads
    a_valid_moves: assert property (@(posedge clk) disable iff (!rst_n)
        en[ST_MUL] |=> vld_reg[ST_MUL] == $past(vld_reg[ST_IN]))
        else $error("valid bit lost between capture and multiply stages");

endmodule
`default_nettype wire

// File: bench/ray_obb_slab_intersection_unit_tb.sv
// testbench for the ray/oriented-box slab unit: self-checking with a bit-true predictor
`timescale 1ns / 1ps
`default_nettype none
module ray_obb_slab_intersection_unit_tb;
    import rayobb_pkg::*;

    localparam int LATENCY   = 39;
    localparam int N_RANDOM  = 850;
    localparam longint LIMIT = 400000;

    // unpacked box request
    typedef struct {
        logic signed [COORD_W-1:0] ctr [3];
        logic [3*AXIS_W-1:0]       ax  [3];
        logic [HALF_W-1:0]         half[3];
    } box_t;

    typedef struct {
        logic                      hit;
        logic signed [COORD_W-1:0] distance;
    } hit_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_addr = '0;
    logic [COORD_W-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    ray_obb_slab_intersection_unit dut (.*);

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // shadow of the ray registers
    logic signed [COORD_W-1:0] org[3];
    logic signed [AXIS_W-1:0]  dir[3];
    logic [HALF_W-1:0]         ray_len;

    logic [IN_TDATA_W-1:0] pending_boxes[$];
    hit_t                  expected_hits[$];
    int  errors = 0;
    longint cycles = 0;
    bit  hold_off = 1'b0;      // long receiver stall, requested by the stimulus
    int  hold_cnt = 0;
    bit  sender_pause = 1'b0;

    // handshakes as seen at the rising edge
    logic s_axis_tready_q = 1'b0;
    logic m_axis_tvalid_q = 1'b0;

    // ---------------------------------------------------------------- predictor

    function automatic longint floor_shr(longint x, int s);
        return x >>> s;        // arithmetic shift is a floor
    endfunction

    function automatic longint axis_part(logic [3*AXIS_W-1:0] a, int k);
        logic signed [AXIS_W-1:0] v;
        v = a[k*AXIS_W +: AXIS_W];
        return longint'(v);
    endfunction

    // (num << PROD_FRAC) / den, truncated toward zero, saturated
    function automatic longint slab_div(longint num, longint den);
        bit neg;
        longint unsigned un, ud, q, r, cap;
        neg = (num < 0) != (den < 0);
        un = num < 0 ? -num : num;
        ud = den < 0 ? -den : den;
        cap = 64'd1 << (COORD_W - 1);
        q = un / ud;
        r = un % ud;
        if (q >= cap)
            q = cap;
        else
        begin
            for (int i = 0; i < PROD_FRAC; i++)
            begin
                q = q << 1;
                r = r << 1;
                if (r >= ud)
                begin
                    r = r - ud;
                    q = q | 1;
                end
                if (q >= cap)
                begin
                    q = cap;
                    break;
                end
            end
        end
        if (neg)
            return -longint'(q);
        return q >= cap ? longint'(cap - 1) : longint'(q);
    endfunction

    function automatic hit_t slab_hit(box_t b);
        longint c[3], hi, lo, e, f, t1, t2, s, tmin, tmax, t_sel, ae;
        longint unsigned fa;
        bit miss;
        hit_t res;
        tmin = -(longint'(1) << (COORD_W - 1));
        tmax = (longint'(1) << (COORD_W - 1)) - 1;
        miss = 1'b0;
        for (int k = 0; k < 3; k++)
            c[k] = longint'(b.ctr[k]) - longint'(org[k]);
        for (int i = 0; i < 3 && !miss; i++)
        begin
            hi = 0;
            lo = 0;
            f = 0;
            for (int k = 0; k < 3; k++)
            begin
                hi += axis_part(b.ax[i], k) * floor_shr(c[k], AXIS_FRAC);
                lo += axis_part(b.ax[i], k) * (c[k] & ((64'd1 << AXIS_FRAC) - 1));
                f  += axis_part(b.ax[i], k) * longint'(dir[k]);
            end
            e = hi + floor_shr(lo, AXIS_FRAC);
            fa = f < 0 ? -f : f;
            if (fa > longint'(NEAR_ZERO))
            begin
                t1 = slab_div(e + longint'(b.half[i]), f);
                t2 = slab_div(e - longint'(b.half[i]), f);
                if (t1 > t2)
                begin
                    s = t1;
                    t1 = t2;
                    t2 = s;
                end
                if (t1 > tmin) tmin = t1;
                if (t2 < tmax) tmax = t2;
                if (tmin > tmax) miss = 1'b1;
            end
            else
            begin
                ae = e < 0 ? -e : e;
                if (ae > longint'(b.half[i])) miss = 1'b1;
            end
        end
        if (miss)
        begin
            res.hit = 1'b0;
            res.distance = '0;
        end
        else
        begin
            t_sel = tmin >= 0 ? tmin : tmax;
            res.hit = t_sel >= 0 && t_sel <= longint'(ray_len);
            res.distance = t_sel[COORD_W-1:0];
        end
        return res;
    endfunction

    function automatic box_t unpack_box(logic [IN_TDATA_W-1:0] d);
        box_t b;
        for (int k = 0; k < 3; k++)
        begin
            b.ctr[k]  = d[k*COORD_W +: COORD_W];
            b.ax[k]   = d[3*COORD_W + k*3*AXIS_W +: 3*AXIS_W];
            b.half[k] = d[3*COORD_W + 9*AXIS_W + k*HALF_W +: HALF_W];
        end
        return b;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_box(box_t b);
        logic [IN_TDATA_W-1:0] d;
        d = '0;
        for (int k = 0; k < 3; k++)
        begin
            d[k*COORD_W +: COORD_W] = b.ctr[k];
            d[3*COORD_W + k*3*AXIS_W +: 3*AXIS_W] = b.ax[k];
            d[3*COORD_W + 9*AXIS_W + k*HALF_W +: HALF_W] = b.half[k];
        end
        return d;
    endfunction

    // ---------------------------------------------------------------- driver

    // box requests go out at the falling edge, with an idle gap drawn at random for each box
    int box_gap = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready_q)
            begin
                // previous request was taken at the rising edge
                box_gap = $urandom_range(0, 4);
            end
            if (!(s_axis_tvalid && !s_axis_tready_q))
            begin
                if (box_gap > 0 || sender_pause || pending_boxes.size() == 0)
                begin
                    if (box_gap > 0) box_gap--;
                    s_axis_tvalid <= 1'b0;
                end
                else
                begin
                    s_axis_tdata  <= pending_boxes.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        s_axis_tready_q <= s_axis_tready;
        cycles <= cycles + 1;
        if (rst_n && s_axis_tvalid && s_axis_tready)
            expected_hits.push_back(slab_hit(unpack_box(s_axis_tdata)));
    end

    // receiver: random stalls between transfers, plus the long hold-off
    int sink_wait = 0;
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_off)
            begin
                m_axis_tready <= 1'b0;
                hold_cnt++;
            end
            else if (m_axis_tready && m_axis_tvalid_q)
            begin
                sink_wait = $urandom_range(0, 4);
                m_axis_tready <= sink_wait == 0;
            end
            else if (sink_wait > 0)
            begin
                sink_wait--;
                m_axis_tready <= sink_wait == 0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // ---------------------------------------------------------------- monitor

    always @(posedge clk)
    begin
        hit_t want;
        m_axis_tvalid_q <= m_axis_tvalid && m_axis_tready;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_hits.size() == 0)
            begin
                $display("%0t: result with no request pending, got hit %0b dist %0d",
                         $realtime, m_axis_tdata[0], $signed(m_axis_tdata[COORD_W:1]));
                errors++;
            end
            else
            begin
                want = expected_hits.pop_front();
                if (m_axis_tdata[0] !== want.hit)
                begin
                    $display("%0t: hit mismatch, expected %0b actual %0b",
                             $realtime, want.hit, m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tdata[COORD_W:1] !== want.distance)
                begin
                    $display("%0t: distance mismatch, expected %0d actual %0d",
                             $realtime, want.distance, $signed(m_axis_tdata[COORD_W:1]));
                    errors++;
                end
            end
        end
    end

    // timeout
    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COORD_W-1:0] val);
        @(negedge clk);
        cfg_addr  <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        unique case (idx)
            REG_ORG_X: org[0] = val;
            REG_ORG_Y: org[1] = val;
            REG_ORG_Z: org[2] = val;
            REG_DIR_X: dir[0] = val[AXIS_W-1:0];
            REG_DIR_Y: dir[1] = val[AXIS_W-1:0];
            REG_DIR_Z: dir[2] = val[AXIS_W-1:0];
            REG_LEN:   ray_len = val[HALF_W-1:0];
            default:   ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // wait until the pipe has drained
    task automatic drain();
        while (pending_boxes.size() != 0 || s_axis_tvalid || expected_hits.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic set_ray(logic signed [COORD_W-1:0] ox, oy, oz,
                           logic signed [AXIS_W-1:0] dx, dy, dz,
                           logic [HALF_W-1:0] len);
        write_reg(REG_ORG_X, ox);
        write_reg(REG_ORG_Y, oy);
        write_reg(REG_ORG_Z, oz);
        write_reg(REG_DIR_X, COORD_W'(dx));
        write_reg(REG_DIR_Y, COORD_W'(dy));
        write_reg(REG_DIR_Z, COORD_W'(dz));
        write_reg(REG_LEN, COORD_W'(len));
    endtask

    function automatic logic [3*AXIS_W-1:0] axis3(int x, int y, int z);
        logic [3*AXIS_W-1:0] a;
        a = {AXIS_W'(z), AXIS_W'(y), AXIS_W'(x)};
        return a;
    endfunction

    function automatic int small_coord();
        return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
    endfunction

    // random unit-ish axes (a permuted, signed identity frame) or raw noise
    function automatic box_t rand_box(int mode);
        box_t b;
        int p, s;
        p = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++)
        begin
            if (mode == 0)
            begin
                b.ctr[k]  = small_coord();
                b.half[k] = HALF_W'($urandom_range(0, 32'h0010_0000));
                s = $urandom_range(0, 1) ? 16384 : -16384;
                case ((k + p) % 3)
                    0: b.ax[k] = axis3(s, $urandom_range(0, 40) - 20, 0);
                    1: b.ax[k] = axis3(0, s, $urandom_range(0, 40) - 20);
                    default: b.ax[k] = axis3($urandom_range(0, 40) - 20, 0, s);
                endcase
            end
            else
            begin
                b.ctr[k]  = $urandom;
                b.half[k] = HALF_W'({$urandom} >> 1);
                b.ax[k]   = (3*AXIS_W)'({$urandom, $urandom});
            end
        end
        return b;
    endfunction

    task automatic push_box(box_t b);
        pending_boxes.push_back(pack_box(b));
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            push_box(rand_box($urandom_range(0, 9) < 8 ? 0 : 1));
        drain();
    endtask

    initial
    begin
        box_t b;
        org = '{0, 0, 0};
        dir = '{16384, 0, 0};
        ray_len = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset ray along +x, length 100
        set_ray(0, 0, 0, 16384, 0, 0, 31'd100 << 16);
        b.ax = '{axis3(16384, 0, 0), axis3(0, 16384, 0), axis3(0, 0, 16384)};
        // box ahead, hit
        b.ctr = '{32'sd10 << 16, 0, 0};
        b.half = '{31'd1 << 16, 31'd1 << 16, 31'd1 << 16};
        push_box(b);
        // origin inside
        b.ctr = '{0, 0, 0};
        push_box(b);
        // behind: late miss
        b.ctr = '{-(32'sd10 << 16), 0, 0};
        push_box(b);
        // beyond length: late miss
        b.ctr = '{32'sd200 << 16, 0, 0};
        push_box(b);
        // parallel axis fails: early miss
        b.ctr = '{32'sd10 << 16, 32'sd5 << 16, 0};
        push_box(b);
        // field extremes
        b.ctr = '{32'h7fffffff, 32'h80000000, 32'h7fffffff};
        b.half = '{31'h7fffffff, 31'h7fffffff, 0};
        push_box(b);
        b.ctr = '{32'h80000000, 32'h7fffffff, 32'h80000000};
        b.half = '{31'h7fffffff, 31'h7fffffff, 31'h7fffffff};
        b.ax = '{axis3(-32768, 32767, -1), axis3(32767, -32768, 0),
                 axis3(-1, -1, -32768)};
        push_box(b);
        // zero axes: parallel to every axis
        b.ax = '{'0, '0, '0};
        b.ctr = '{0, 0, 0};
        push_box(b);
        // tiny axis x components (1, then all -1): projected direction still above the near-zero bound
        b.ax = '{axis3(1, 16384, 0), axis3(16384, 0, 0), axis3(0, 0, 16384)};
        b.ctr = '{0, 32'sd1 << 16, 0};
        b.half = '{31'd1 << 14, 31'd1 << 16, 31'd1 << 16};
        push_box(b);
        b.ax[0] = '1;
        b.ax[1] = '1;
        b.ax[2] = '1;
        push_box(b);
        drain();

        // every direction component zero, length at maximum
        set_ray(0, 0, 0, 0, 0, 0, 31'h7fffffff);
        b.ax = '{axis3(16384, 0, 0), axis3(0, 16384, 0), axis3(0, 0, 16384)};
        b.ctr = '{0, 0, 0};
        b.half = '{31'd1 << 16, 31'd1 << 16, 31'd1 << 16};
        push_box(b);
        b.ctr = '{32'sd3 << 16, 0, 0};
        push_box(b);
        drain();

        // extreme ray: origin corners, unit direction components of mixed sign
        set_ray(32'h7fffffff, 32'h80000000, 32'h7fffffff, -16384, 16384, -16384, 31'h7fffffff);
        random_phase(40);
        set_ray(32'h80000000, 32'h7fffffff, 32'h80000000, 16384, -16384, 16384, 0);
        random_phase(40);

        // long receiver hold-off while the sender keeps offering, then a pause
        set_ray(small_coord(), small_coord(), small_coord(), 9459, 9459, 9459, 31'h0100_0000);
        hold_off = 1'b1;
        for (int i = 0; i < 120; i++)
            push_box(rand_box(0));
        while (hold_cnt < 300) @(posedge clk);
        hold_off = 1'b0;
        sender_pause = 1'b1;
        while (expected_hits.size() != 0 || s_axis_tvalid) @(posedge clk);
        sender_pause = 1'b0;
        drain();

        // random rays and boxes
        for (int ph = 0; ph < 6; ph++)
        begin
            set_ray(small_coord(), small_coord(), small_coord(),
                    AXIS_W'($urandom_range(0, 32768) - 16384),
                    AXIS_W'($urandom_range(0, 32768) - 16384),
                    AXIS_W'($urandom_range(0, 32768) - 16384),
                    HALF_W'($urandom_range(0, 32'h0080_0000)));
            random_phase(N_RANDOM / 6 - 35);
        end

        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
`default_nettype wire

// File: filelist.f
hdl/rayobb_pkg.sv
hdl/rayobb_div.sv
hdl/ray_obb_slab_intersection_unit.sv
bench/ray_obb_slab_intersection_unit_tb.sv
